/* rtl/prc_pkg.sv */
// Package for the pen route cost accumulator.
// Holds the configuration register record, its field widths and register indexes.
// No dependencies.
package prc_pkg;

    localparam int COLOR_W = 8;
    localparam int CFG_COST_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int OUT_COST_W = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_HUE_TOLERANCE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIFT_PENALTY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HUE_PENALTY = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FREE_RUN_LIMIT = 2'd3;

    typedef struct packed {
        logic [COLOR_W-1:0] hue_tolerance;
        logic [CFG_COST_W-1:0] lift_penalty;
        logic [CFG_COST_W-1:0] hue_penalty;
        logic [CFG_COST_W-1:0] free_run_limit;
    } prc_cfg_t;

endpackage

/* rtl/pen_route_cost_accumulator.sv */
// Pen route cost accumulator, top level.
// Holds the configuration registers, input register, route state and result register.
// Depends on prc_pkg and prc_step.
//
// Usage: route points arrive on the input channel (in_valid/in_ready) one item
// per point; last_point marks the final point of a route. For each route one
// result item (route_cost, cost_saturated) leaves on the output channel
// (out_valid/out_ready). A one-point route gives zero.
// Throughput: one point per cycle, also across route ends while results are
// taken; the single register stage between input and result register sets it.
// An accepted point is held in the input register and folded into the route
// state when it moves on; for a last point the result register is loaded at
// that same edge, which raises out_valid.
// Non-last points keep flowing while a result waits; a last point waits in the
// input register until the result register is free or being emptied, and while
// it waits in_ready is low.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the next
// edge and must happen only while no point is in flight.
// Reset (rst_n low, asynchronous) clears route state and both registers' valid
// flags and returns the configuration to threshold 0, costs 0, run limit 1.
module pen_route_cost_accumulator
    import prc_pkg::*;
#(
    parameter int COORD_WIDTH = 10,
    parameter int COST_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_WIDTH-1:0] pixel_x,
    input  logic [COORD_WIDTH-1:0] pixel_y,
    input  logic [COLOR_W-1:0]     pixel_color,
    input  logic                   last_point,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_COST_W-1:0]  route_cost,
    output logic                   cost_saturated
);

    localparam int EXT_W = (COST_WIDTH > OUT_COST_W) ? COST_WIDTH : OUT_COST_W;

    prc_cfg_t cfg_reg;

    logic                   in_valid_reg;
    logic [COORD_WIDTH-1:0] x_reg;
    logic [COORD_WIDTH-1:0] y_reg;
    logic [COLOR_W-1:0]     color_reg;
    logic                   last_reg;

    logic                        have_prev_reg;
    logic [COORD_WIDTH-1:0]      prev_x_reg;
    logic [COORD_WIDTH-1:0]      prev_y_reg;
    logic [COLOR_W-1:0]          prev_color_reg;
    logic signed [COORD_WIDTH:0] last_dx_reg;
    logic signed [COORD_WIDTH:0] last_dy_reg;
    logic [CFG_COST_W-1:0]       run_reg;
    logic [COST_WIDTH-1:0]       sum_reg;
    logic                        ovf_reg;

    logic                   out_valid_reg;
    logic [OUT_COST_W-1:0]  cost_reg;
    logic                   sat_reg;

    logic signed [COORD_WIDTH:0] step_dx;
    logic signed [COORD_WIDTH:0] step_dy;
    logic [CFG_COST_W-1:0]       run_next;
    logic [COST_WIDTH-1:0]       step_sum;
    logic                        step_ovf;
    logic [COST_WIDTH-1:0]       sum_final;
    logic                        ovf_final;
    logic [EXT_W-1:0]            sum_ext;
    logic                        advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_tolerance <= '0;
            cfg_reg.lift_penalty <= '0;
            cfg_reg.hue_penalty <= '0;
            cfg_reg.free_run_limit <= CFG_COST_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_HUE_TOLERANCE:  cfg_reg.hue_tolerance <= cfg_data[COLOR_W-1:0];
                REG_LIFT_PENALTY:   cfg_reg.lift_penalty <= cfg_data;
                REG_HUE_PENALTY:    cfg_reg.hue_penalty <= cfg_data;
                REG_FREE_RUN_LIMIT: cfg_reg.free_run_limit <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Handshake: a held point moves on unless it ends a route and the result is stuck
    assign advance = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg <= pixel_x;
            y_reg <= pixel_y;
            color_reg <= pixel_color;
            last_reg <= last_point;
        end
    end

    prc_step #(
        .COORD_WIDTH(COORD_WIDTH),
        .COST_WIDTH (COST_WIDTH)
    ) u_step (
        .cfg            (cfg_reg),
        .prev_x         (prev_x_reg),
        .prev_y         (prev_y_reg),
        .prev_color     (prev_color_reg),
        .last_dx        (last_dx_reg),
        .last_dy        (last_dy_reg),
        .run_length     (run_reg),
        .sum            (sum_reg),
        .overflowed     (ovf_reg),
        .point_x        (x_reg),
        .point_y        (y_reg),
        .point_color    (color_reg),
        .step_dx        (step_dx),
        .step_dy        (step_dy),
        .run_length_next(run_next),
        .sum_next       (step_sum),
        .overflowed_next(step_ovf)
    );

    // The first point of a route adds nothing
    assign sum_final = have_prev_reg ? step_sum : sum_reg;
    assign ovf_final = have_prev_reg ? step_ovf : ovf_reg;
    assign sum_ext = EXT_W'(sum_final);

    // Route state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_color_reg <= '0;
            last_dx_reg <= '0;
            last_dy_reg <= '0;
            run_reg <= '0;
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                have_prev_reg <= 1'b0;
                prev_x_reg <= '0;
                prev_y_reg <= '0;
                prev_color_reg <= '0;
                last_dx_reg <= '0;
                last_dy_reg <= '0;
                run_reg <= '0;
                sum_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                have_prev_reg <= 1'b1;
                prev_x_reg <= x_reg;
                prev_y_reg <= y_reg;
                prev_color_reg <= color_reg;
                if (have_prev_reg)
                begin
                    last_dx_reg <= step_dx;
                    last_dy_reg <= step_dy;
                    run_reg <= run_next;
                end
                sum_reg <= sum_final;
                ovf_reg <= ovf_final;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            cost_reg <= sum_ext[OUT_COST_W-1:0];
            sat_reg <= ovf_final;
        end
    end

    assign out_valid = out_valid_reg;
    assign route_cost = cost_reg;
    assign cost_saturated = sat_reg;

endmodule

/* rtl/prc_step.sv */
// Step cost unit: works out one step's cost and the updated route totals.
// Purely combinational. Depends on prc_pkg.
module prc_step
    import prc_pkg::*;
#(
    parameter int COORD_WIDTH = 10,
    parameter int COST_WIDTH = 32
)
(
    input  prc_cfg_t                cfg,
    input  logic [COORD_WIDTH-1:0]  prev_x,
    input  logic [COORD_WIDTH-1:0]  prev_y,
    input  logic [COLOR_W-1:0]      prev_color,
    input  logic signed [COORD_WIDTH:0] last_dx,
    input  logic signed [COORD_WIDTH:0] last_dy,
    input  logic [CFG_COST_W-1:0]   run_length,
    input  logic [COST_WIDTH-1:0]   sum,
    input  logic                    overflowed,
    input  logic [COORD_WIDTH-1:0]  point_x,
    input  logic [COORD_WIDTH-1:0]  point_y,
    input  logic [COLOR_W-1:0]      point_color,
    output logic signed [COORD_WIDTH:0] step_dx,
    output logic signed [COORD_WIDTH:0] step_dy,
    output logic [CFG_COST_W-1:0]   run_length_next,
    output logic [COST_WIDTH-1:0]   sum_next,
    output logic                    overflowed_next
);

    localparam int STEP_W = ((COORD_WIDTH > CFG_COST_W) ? COORD_WIDTH : CFG_COST_W) + 1;
    localparam int SUM_W = ((COST_WIDTH > STEP_W) ? COST_WIDTH : STEP_W) + 1;

    logic signed [COORD_WIDTH:0] dx;
    logic signed [COORD_WIDTH:0] dy;
    logic [COORD_WIDTH:0]        abs_x;
    logic [COORD_WIDTH:0]        abs_y;
    logic [COORD_WIDTH:0]        cheb_len;
    logic signed [COLOR_W:0]     cdiff;
    logic [COLOR_W:0]            cdiff_abs;
    logic [STEP_W-1:0]           base_cost;
    logic [STEP_W-1:0]           step_charge;
    logic [CFG_COST_W-1:0]       run_limit;
    logic                        free_step;
    logic [SUM_W-1:0]            sum_wide;

    // Deltas are previous minus current, as signed values one bit wider
    assign dx = $signed({1'b0, prev_x}) - $signed({1'b0, point_x});
    assign dy = $signed({1'b0, prev_y}) - $signed({1'b0, point_y});
    assign abs_x = $unsigned(dx[COORD_WIDTH] ? -dx : dx);
    assign abs_y = $unsigned(dy[COORD_WIDTH] ? -dy : dy);
    assign cheb_len = (abs_x > abs_y) ? abs_x : abs_y;

    assign cdiff = $signed({1'b0, prev_color}) - $signed({1'b0, point_color});
    assign cdiff_abs = cdiff[COLOR_W] ? (COLOR_W+1)'(-cdiff) : cdiff;

    // Chebyshev distance plus pen-lift or colour-change surcharge
    always_comb
    begin
        base_cost = STEP_W'(cheb_len);
        if (cheb_len > (COORD_WIDTH+1)'(1))
        begin
            step_charge = base_cost + STEP_W'(cfg.lift_penalty);
        end
        else if (cdiff_abs > (COLOR_W+1)'(cfg.hue_tolerance))
        begin
            step_charge = base_cost + STEP_W'(cfg.hue_penalty);
        end
        else
        begin
            step_charge = base_cost;
        end
    end

    // Straight unit steps are free up to the run limit; a zero limit acts as one
    assign run_limit = (cfg.free_run_limit == '0) ? CFG_COST_W'(1) : cfg.free_run_limit;
    assign free_step = (step_charge == STEP_W'(1)) && (dx == last_dx) && (dy == last_dy)
                       && (run_length < run_limit);
    assign run_length_next = free_step ? (run_length + CFG_COST_W'(1)) : '0;

    // Saturating accumulate
    assign sum_wide = SUM_W'(sum) + (free_step ? '0 : SUM_W'(step_charge));

    always_comb
    begin
        if (|sum_wide[SUM_W-1:COST_WIDTH])
        begin
            sum_next = '1;
            overflowed_next = 1'b1;
        end
        else
        begin
            sum_next = sum_wide[COST_WIDTH-1:0];
            overflowed_next = overflowed;
        end
    end

    assign step_dx = dx;
    assign step_dy = dy;

endmodule
